[hw/rtl/sbdt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbdt_pkg: shared types, codes and bitmap helpers
// Word types, operation and status codes, controller states and the
// orientation functions used by the table datapath.
// ----------------------------------------------------------------------------
package sbdt_pkg;

  localparam int TableEntries = 256;
  localparam int MaxSide      = 6;
  localparam int PlaneBits    = MaxSide * MaxSide;
  localparam int IdxBits      = $clog2(TableEntries);
  localparam int CntBits      = IdxBits + 1;
  localparam int SideBits     = 3;
  localparam int EntryBits    = 2 * PlaneBits + 2 * SideBits;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_APPEND = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_STORED    = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_READ_OK   = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_READ,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]           operation;
    logic [PlaneBits-1:0] wall_bits;
    logic [PlaneBits-1:0] stone_bits;
    logic [SideBits-1:0]  width;
    logic [SideBits-1:0]  height;
    logic [7:0]           read_index;
  } in_word_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [7:0]           entry_index;
    logic [2:0]           orientation;
    logic [PlaneBits-1:0] wall_out;
    logic [PlaneBits-1:0] stone_out;
    logic [SideBits-1:0]  width_out;
    logic [SideBits-1:0]  height_out;
    logic [8:0]           entries_used;
  } out_word_t;

  typedef struct packed {
    logic [PlaneBits-1:0] wall;
    logic [PlaneBits-1:0] stone;
    logic [SideBits-1:0]  w;
    logic [SideBits-1:0]  h;
  } bitmap_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input word
    logic scan_start; // reset scan index
    logic rd_issue;   // read entry at scan index
    logic rd_user;    // read entry at read_index
    logic scan_next;  // compare entry, advance scan index on a miss
    logic do_append;  // write entry, bump count
    logic do_clear;   // zero count
    logic set_result; // build output word
    logic [2:0] res;  // result status to build
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;  // scan index reached count
    logic hit;        // stored entry matches some orientation
    logic full;       // count at capacity
    logic idx_ok;     // read index below count
    op_t  op;
  } stat_t;

  function automatic logic [SideBits-1:0] clamp_side(input logic [SideBits-1:0] v);
    clamp_side = (v > SideBits'(MaxSide)) ? SideBits'(MaxSide) : v;
  endfunction

  function automatic logic [PlaneBits-1:0] plane_clean(input logic [PlaneBits-1:0] p,
      input logic [SideBits-1:0] w, input logic [SideBits-1:0] h);
    logic [PlaneBits-1:0] o;
    o = '0;
    for (int y = 0; y < MaxSide; y++)
      for (int x = 0; x < MaxSide; x++)
        if (x < w && y < h) o[MaxSide*y+x] = p[MaxSide*y+x];
    plane_clean = o;
  endfunction

  function automatic logic [PlaneBits-1:0] plane_rotate(input logic [PlaneBits-1:0] p,
      input logic [SideBits-1:0] w, input logic [SideBits-1:0] h);
    logic [PlaneBits-1:0] o;
    o = '0;
    for (int x = 0; x < MaxSide; x++)
      for (int y = 0; y < MaxSide; y++)
        for (int n = 0; n < MaxSide; n++)
          if (x < w && y < h && n == h - 1 - y && p[MaxSide*y+x])
            o[MaxSide*x+n] = 1'b1;
    plane_rotate = o;
  endfunction

  function automatic logic [PlaneBits-1:0] plane_flip(input logic [PlaneBits-1:0] p,
      input logic [SideBits-1:0] h);
    logic [PlaneBits-1:0] o;
    o = '0;
    for (int y = 0; y < MaxSide; y++)
      for (int s = 0; s < MaxSide; s++)
        if (y < h && s == h - 1 - y)
          o[MaxSide*y +: MaxSide] = p[MaxSide*s +: MaxSide];
    plane_flip = o;
  endfunction

  function automatic bitmap_t bm_rotate(input bitmap_t b);
    bitmap_t r;
    r.wall  = plane_rotate(b.wall, b.w, b.h);
    r.stone = plane_rotate(b.stone, b.w, b.h);
    r.w     = b.h;
    r.h     = b.w;
    bm_rotate = r;
  endfunction

endpackage

[hw/rtl/sbdt_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbdt_ram: generic single-port RAM
// One write or one read per cycle; read data registered.
// ----------------------------------------------------------------------------
module sbdt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[hw/rtl/sbdt_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbdt_datapath: entry store, orientation set and match logic
// Holds the cleaned offered bitmap in all eight orientations and compares
// one stored entry per read against them.
// ----------------------------------------------------------------------------
module sbdt_datapath (
  input  logic                clk,
  input  logic                rst,
  input  sbdt_pkg::in_word_t  in_word,
  input  sbdt_pkg::cmd_t      cmd,
  output sbdt_pkg::stat_t     stat,
  output sbdt_pkg::out_word_t out_word
);

  sbdt_pkg::bitmap_t             cur;
  sbdt_pkg::bitmap_t             orient [8];
  sbdt_pkg::bitmap_t             orient_next [8];
  sbdt_pkg::bitmap_t             cleaned;
  sbdt_pkg::op_t                 op;
  logic [7:0]                    read_index;
  logic [sbdt_pkg::CntBits-1:0]  count;
  logic [sbdt_pkg::CntBits-1:0]  scan;
  logic [sbdt_pkg::IdxBits-1:0]  hit_idx;
  logic [sbdt_pkg::IdxBits-1:0]  ram_addr;
  logic [sbdt_pkg::EntryBits-1:0] ram_rdata;
  sbdt_pkg::bitmap_t             entry;
  logic [7:0]                    match_vec;
  logic [2:0]                    match_o;
  logic                          match_any;
  logic [2:0]                    hit_o;
  logic                          hit;
  sbdt_pkg::out_word_t           out_next;

  always_comb begin
    cleaned.w     = sbdt_pkg::clamp_side(in_word.width);
    cleaned.h     = sbdt_pkg::clamp_side(in_word.height);
    cleaned.wall  = sbdt_pkg::plane_clean(in_word.wall_bits, cleaned.w, cleaned.h);
    cleaned.stone = sbdt_pkg::plane_clean(in_word.stone_bits, cleaned.w, cleaned.h);
  end

  // orientations built one rotation per cycle from the captured word
  always_comb begin
    orient_next[0] = cur;
    orient_next[1] = sbdt_pkg::bm_rotate(orient[0]);
    orient_next[2] = sbdt_pkg::bm_rotate(orient[1]);
    orient_next[3] = sbdt_pkg::bm_rotate(orient[2]);
    orient_next[4].wall  = sbdt_pkg::plane_flip(cur.wall, cur.h);
    orient_next[4].stone = sbdt_pkg::plane_flip(cur.stone, cur.h);
    orient_next[4].w     = cur.w;
    orient_next[4].h     = cur.h;
    orient_next[5] = sbdt_pkg::bm_rotate(orient[4]);
    orient_next[6] = sbdt_pkg::bm_rotate(orient[5]);
    orient_next[7] = sbdt_pkg::bm_rotate(orient[6]);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur        <= cleaned;
      op         <= sbdt_pkg::op_t'(in_word.operation);
      read_index <= in_word.read_index;
    end
    for (int k = 0; k < 8; k++) begin
      orient[k] <= orient_next[k];
    end
  end

  assign ram_addr = cmd.do_append ? count[sbdt_pkg::IdxBits-1:0] :
                    cmd.rd_user   ? read_index[sbdt_pkg::IdxBits-1:0] :
                                    scan[sbdt_pkg::IdxBits-1:0];

  sbdt_ram #(
    .Width(sbdt_pkg::EntryBits),
    .Depth(sbdt_pkg::TableEntries)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.do_append),
    .addr (ram_addr),
    .wdata(cur),
    .rdata(ram_rdata)
  );

  assign entry = sbdt_pkg::bitmap_t'(ram_rdata);

  always_comb begin
    match_o = '0;
    for (int k = 0; k < 8; k++) begin
      match_vec[k] = (orient[k] == entry);
    end
    for (int k = 7; k >= 0; k--) begin
      if (match_vec[k]) match_o = 3'(k);
    end
    match_any = |match_vec;
  end

  // scan: rd_issue reads entry at scan; next cycle compare (scan_next)
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      scan  <= '0;
      hit   <= 1'b0;
    end else begin
      if (cmd.scan_start) begin
        scan <= '0;
        hit  <= 1'b0;
      end else if (cmd.scan_next) begin
        if (match_any) begin
          hit     <= 1'b1;
          hit_o   <= match_o;
          hit_idx <= scan[sbdt_pkg::IdxBits-1:0];
        end else begin
          scan <= scan + 1'b1;
        end
      end
      if (cmd.do_clear) begin
        count <= '0;
      end else if (cmd.do_append) begin
        count <= count + 1'b1;
      end
    end
  end

  always_comb begin
    stat.scan_done = (scan >= count);
    stat.hit       = hit;
    stat.full      = (count >= sbdt_pkg::CntBits'(sbdt_pkg::TableEntries));
    stat.idx_ok    = ({1'b0, read_index} < 9'(count));
    stat.op        = op;
  end

  always_comb begin
    out_next              = '0;
    out_next.status       = cmd.res;
    out_next.entries_used = 9'(count) + 9'(cmd.do_append);
    case (sbdt_pkg::status_t'(cmd.res))
      sbdt_pkg::ST_STORED: begin
        out_next.entry_index = 8'(count);
      end
      sbdt_pkg::ST_DUPLICATE: begin
        out_next.entry_index = 8'(hit_idx);
        out_next.orientation = hit_o;
      end
      sbdt_pkg::ST_READ_OK: begin
        out_next.entry_index = read_index;
        out_next.wall_out    = entry.wall;
        out_next.stone_out   = entry.stone;
        out_next.width_out   = entry.w;
        out_next.height_out  = entry.h;
      end
      sbdt_pkg::ST_EMPTY: begin
        if (cmd.do_clear) out_next.entries_used = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.set_result) begin
      out_word <= out_next;
    end
  end

endmodule

[hw/rtl/sbdt_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbdt_ctrl: operation sequencer
// Accepts a word, steps the datapath through scan, append, read or clear,
// and holds the result until it is taken.
// ----------------------------------------------------------------------------
module sbdt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  sbdt_pkg::stat_t stat,
  output sbdt_pkg::cmd_t  cmd
);

  sbdt_pkg::state_t state, state_next;
  logic [1:0]       warm, warm_next;
  logic             busy;
  logic             out_free;
  logic             emit;

  assign busy = (state != sbdt_pkg::S_IDLE) && (state != sbdt_pkg::S_OUT);

  // output register can take a new result this cycle
  assign out_free = !out_valid || out_ready;

  // S_OUT builds the result unless a valid read already did
  assign emit = !(stat.op == sbdt_pkg::OP_READ && stat.idx_ok);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sbdt_pkg::S_IDLE;
      warm      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      warm  <= warm_next;
      if (cmd.set_result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output register frees when taken, so a new word may enter meanwhile
  assign in_ready = !busy && (!out_valid || out_ready || state == sbdt_pkg::S_IDLE)
                    && !(state == sbdt_pkg::S_OUT);

  always_comb begin
    state_next = state;
    warm_next  = warm;
    case (state)
      sbdt_pkg::S_IDLE: begin
        if (in_valid && in_ready) begin
          state_next = sbdt_pkg::S_CHECK;
          warm_next  = '0;
        end
      end
      sbdt_pkg::S_CHECK: begin
        // wait while the captured word passes through the orientation registers
        warm_next = warm + 1'b1;
        if (warm == 2'd2) begin
          case (stat.op)
            sbdt_pkg::OP_INSERT: state_next = sbdt_pkg::S_SCAN;
            sbdt_pkg::OP_READ:   state_next = stat.idx_ok ? sbdt_pkg::S_READ : sbdt_pkg::S_OUT;
            default:             state_next = sbdt_pkg::S_OUT;
          endcase
          warm_next = '0;
        end
      end
      sbdt_pkg::S_SCAN: begin
        warm_next = ~warm[0] ? 2'd1 : 2'd0;
        if (stat.hit || (stat.scan_done && !warm[0])) state_next = sbdt_pkg::S_OUT;
      end
      sbdt_pkg::S_READ: begin
        warm_next = warm + 1'b1;
        if (warm == 2'd1) begin
          // hold the read data until the output register is free
          warm_next = warm;
          if (out_free) state_next = sbdt_pkg::S_OUT;
        end
      end
      sbdt_pkg::S_OUT: begin
        if (!emit || out_free) state_next = sbdt_pkg::S_IDLE;
      end
      default: state_next = sbdt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      sbdt_pkg::S_IDLE: begin
        cmd.load = in_valid && in_ready;
      end
      sbdt_pkg::S_CHECK: begin
        cmd.scan_start = 1'b1;
      end
      sbdt_pkg::S_SCAN: begin
        // even phase: issue read; odd phase: compare registered data
        cmd.rd_issue  = !warm[0];
        cmd.scan_next = warm[0] && !stat.hit;
      end
      sbdt_pkg::S_READ: begin
        cmd.rd_user = 1'b1;
        if (warm == 2'd1 && out_free) begin
          cmd.set_result = 1'b1;
          cmd.res        = sbdt_pkg::ST_READ_OK;
        end
      end
      sbdt_pkg::S_OUT: begin
        if (emit && out_free) begin
          cmd.set_result = 1'b1;
          case (stat.op)
            sbdt_pkg::OP_INSERT, sbdt_pkg::OP_APPEND: begin
              if (stat.hit) begin
                cmd.res = sbdt_pkg::ST_DUPLICATE;
              end else if (stat.full) begin
                cmd.res = sbdt_pkg::ST_FULL;
              end else begin
                cmd.res       = sbdt_pkg::ST_STORED;
                cmd.do_append = 1'b1;
              end
            end
            sbdt_pkg::OP_CLEAR: begin
              cmd.res      = sbdt_pkg::ST_EMPTY;
              cmd.do_clear = 1'b1;
            end
            default: cmd.res = sbdt_pkg::ST_EMPTY;
          endcase
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[hw/rtl/symmetric_bitmap_dedup_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symmetric_bitmap_dedup_table: orientation-aware bitmap table
// Top level joining the sequencer and the entry datapath.
// ----------------------------------------------------------------------------
// A word carries one operation. A checked insert scans the stored entries up
// to and including the match, each by a read and then a compare against all
// eight orientations of the offered bitmap at once; the single RAM port
// allows one entry per read. Unchecked append, clear and a bad read skip the
// scan; a valid read goes through the read state. One word is worked on at a
// time; the next word can be taken once the sequencer is back in idle after
// the result is built (a valid read builds it in the read state, then passes
// through the output state). The result sits in an output register until
// taken; if an earlier result is still waiting there, the block holds before
// building the new one. Stored entries are in-size bits only; a duplicate
// reports the first matching entry and the lowest matching orientation.
// ----------------------------------------------------------------------------
module symmetric_bitmap_dedup_table (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sbdt_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sbdt_pkg::out_word_t out_data
);

  sbdt_pkg::cmd_t  cmd;
  sbdt_pkg::stat_t stat;

  sbdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sbdt_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .in_word (in_data),
    .cmd     (cmd),
    .stat    (stat),
    .out_word(out_data)
  );

  // a result is built only while no earlier one is pending
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.set_result |-> !out_valid || out_ready)
    else $error("result overwritten");

  // entry count never exceeds capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.entries_used <= 9'(sbdt_pkg::TableEntries))
    else $error("entry count out of range");

  // append and clear never coincide
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.do_append && cmd.do_clear))
    else $error("append and clear together");

endmodule
